// ===== hdl/slt_pkg.sv =====
// slt_pkg: types, codes and constants shared by the source line tokenizer.
// No dependencies.
package slt_pkg;

	localparam int COMMENT_COUNT_BITS = 16;
	localparam int VAL_W = 63;
	localparam int MAX_EV = 3;

	typedef enum logic [3:0] {
		EV_IDCHAR   = 4'd0,
		EV_IDEND    = 4'd1,
		EV_NUMBER   = 4'd2,
		EV_STRCHAR  = 4'd3,
		EV_STREND   = 4'd4,
		EV_SYMBOL   = 4'd5,
		EV_DIGRAPH  = 4'd6,
		EV_EOL      = 4'd7,
		EV_EOF      = 4'd8,
		EV_BADSTR   = 4'd9,
		EV_CCHAR    = 4'd10,
		EV_CLINE    = 4'd11,
		EV_CEND     = 4'd12,
		EV_OVERFLOW = 4'd13
	} ev_kind_t;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUM, M_STR, M_ESC, M_CODE, M_PEND,
		M_LCOM, M_SKIP, M_CSTART, M_CSKIP, M_CTEXT, M_CNL
	} mode_t;

	localparam logic [1:0] CFG_LEGACY = 2'd0;
	localparam logic [1:0] CFG_SKIP   = 2'd1;

	typedef struct packed {
		ev_kind_t          kind;
		logic [VAL_W-1:0]  value;
		logic              expr;
		logic              eqn;
	} event_t;

	typedef struct packed {
		logic [1:0]        n;
		event_t [MAX_EV-1:0] ev;
	} ev_group_t;

	typedef struct packed {
		mode_t                         mode;
		logic [7:0]                    pend;
		logic [63:0]                   acc;
		logic [7:0]                    esc;
		logic [1:0]                    esc_cnt;
		logic [1:0]                    tok_cnt;
		logic                          first_id;
		logic                          expr;
		logic                          eqn;
		logic [COMMENT_COUNT_BITS-1:0] lines;
	} lex_state_t;

	typedef struct packed {
		logic legacy;
		logic skip;
	} cfg_t;

endpackage

// ===== hdl/slt_lexer.sv =====
// slt_lexer: registered lexer state and the combinational next-state and
// event logic for one character. Depends on slt_pkg.
module slt_lexer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            ch,
	input  logic                  eoi,
	input  slt_pkg::cfg_t         cfg,
	output slt_pkg::ev_group_t    evs
);

	slt_pkg::lex_state_t st_q, nx;
	slt_pkg::ev_group_t  g;

	localparam logic [63:0] NUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] OVF_LIM = NUM_MAX / 64'd10;
	localparam logic [slt_pkg::COMMENT_COUNT_BITS-1:0] CNT_MAX = '1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= nx;
		end
	end

	assign evs = g;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	always_comb begin
		logic [3:0]  dig;
		logic [63:0] acc10;
		logic [9:0]  esc10;
		logic        notsign;
		logic        go_idle;
		logic        go_str;
		logic        ovf;
		logic [1:0]  i;
		logic [slt_pkg::COMMENT_COUNT_BITS-1:0] lc;

		nx = st_q;
		g = '0;
		i = 2'd0;
		dig = ch[3:0];
		acc10 = {st_q.acc[60:0], 3'b000} + {st_q.acc[62:0], 1'b0} + {60'd0, dig};
		esc10 = {st_q.esc, 2'b00} + {2'b00, st_q.esc} ;
		esc10 = {esc10[8:0], 1'b0} + {6'd0, dig};
		ovf = (st_q.acc > OVF_LIM) ||
			(st_q.acc == OVF_LIM && {60'd0, dig} > (NUM_MAX - OVF_LIM * 64'd10));
		notsign = st_q.pend == 8'h5C || (st_q.pend == 8'h7E && cfg.legacy);
		go_idle = 1'b0;
		go_str = 1'b0;
		lc = st_q.lines;

		// event push helper pattern: write g.ev[i], bump i
		case (st_q.mode)
			slt_pkg::M_IDENT: begin
				if (!eoi && (is_letter(ch) || is_digit(ch) || ch == 8'h27 || ch == 8'h5F)) begin
					g.ev[i].kind = slt_pkg::EV_IDCHAR; g.ev[i].value = {55'd0, ch}; i = i + 2'd1;
				end else begin
					g.ev[i].kind = slt_pkg::EV_IDEND; i = i + 2'd1;
					if (nx.tok_cnt == 2'd0) nx.first_id = 1'b1;
					if (nx.tok_cnt != 2'd3) nx.tok_cnt = nx.tok_cnt + 2'd1;
					go_idle = 1'b1;
				end
			end
			slt_pkg::M_NUM: begin
				if (!eoi && is_digit(ch)) begin
					if (ovf) begin
						g.ev[i].kind = slt_pkg::EV_OVERFLOW; i = i + 2'd1;
						nx.expr = 1'b0; nx.eqn = 1'b0; nx.tok_cnt = 2'd0;
						nx.first_id = 1'b0; nx.lines = '0;
						nx.acc = '0;
						nx.mode = slt_pkg::M_SKIP;
					end else begin
						nx.acc = acc10;
					end
				end else begin
					g.ev[i].kind = slt_pkg::EV_NUMBER; g.ev[i].value = st_q.acc[62:0];
					i = i + 2'd1;
					if (nx.tok_cnt == 2'd0) nx.first_id = 1'b0;
					if (nx.tok_cnt != 2'd3) nx.tok_cnt = nx.tok_cnt + 2'd1;
					go_idle = 1'b1;
				end
			end
			slt_pkg::M_STR: go_str = 1'b1;
			slt_pkg::M_ESC: begin
				if (eoi || ch == 8'h0A) begin
					go_str = 1'b1;
				end else begin
					nx.mode = slt_pkg::M_STR;
					g.ev[i].kind = slt_pkg::EV_STRCHAR;
					case (ch)
						8'h61: begin g.ev[i].value = 63'd7; i = i + 2'd1; end
						8'h62: begin g.ev[i].value = 63'd8; i = i + 2'd1; end
						8'h66: begin g.ev[i].value = 63'd12; i = i + 2'd1; end
						8'h6E: begin g.ev[i].value = 63'd10; i = i + 2'd1; end
						8'h72: begin g.ev[i].value = 63'd13; i = i + 2'd1; end
						8'h74: begin g.ev[i].value = 63'd9; i = i + 2'd1; end
						8'h76: begin g.ev[i].value = 63'd11; i = i + 2'd1; end
						8'h5C, 8'h27, 8'h22: begin
							g.ev[i].value = {55'd0, ch}; i = i + 2'd1;
						end
						default: begin
							g.ev[i].kind = slt_pkg::EV_IDCHAR;
							if (is_digit(ch)) begin
								nx.esc = {4'd0, dig};
								nx.esc_cnt = 2'd1;
								nx.mode = slt_pkg::M_CODE;
							end
						end
					endcase
				end
			end
			slt_pkg::M_CODE: begin
				if (!eoi && is_digit(ch) && esc10 < 10'd256) begin
					nx.esc = esc10[7:0];
					if (st_q.esc_cnt == 2'd2) begin
						g.ev[i].kind = slt_pkg::EV_STRCHAR;
						g.ev[i].value = {55'd0, esc10[7:0]}; i = i + 2'd1;
						nx.esc_cnt = 2'd0;
						nx.mode = slt_pkg::M_STR;
					end else begin
						nx.esc_cnt = st_q.esc_cnt + 2'd1;
					end
				end else begin
					g.ev[i].kind = slt_pkg::EV_STRCHAR;
					g.ev[i].value = {55'd0, st_q.esc}; i = i + 2'd1;
					nx.esc_cnt = 2'd0;
					go_str = 1'b1;
				end
			end
			slt_pkg::M_PEND: begin
				if (!eoi && st_q.pend == 8'h3A && ch == 8'h2D && st_q.tok_cnt == 2'd1
						&& st_q.first_id) begin
					nx.lines = {{(slt_pkg::COMMENT_COUNT_BITS-1){1'b0}}, 1'b1};
					nx.mode = slt_pkg::M_CSTART;
				end else if (!eoi && st_q.pend == 8'h7C && ch == 8'h7C) begin
					nx.mode = slt_pkg::M_LCOM;
				end else begin
					g.ev[i].kind = slt_pkg::EV_DIGRAPH;
					if (!eoi && st_q.pend == ch && st_q.pend == 8'h2B) g.ev[i].value = 63'd0;
					else if (!eoi && st_q.pend == ch && st_q.pend == 8'h2E) g.ev[i].value = 63'd1;
					else if (!eoi && st_q.pend == ch && st_q.pend == 8'h2D) g.ev[i].value = 63'd2;
					else if (!eoi && st_q.pend == ch && st_q.pend == 8'h2A) g.ev[i].value = 63'd3;
					else if (!eoi && st_q.pend == ch && st_q.pend == 8'h3D) g.ev[i].value = 63'd4;
					else if (!eoi && st_q.pend == 8'h3C && ch == 8'h2D) g.ev[i].value = 63'd5;
					else if (!eoi && ch == 8'h3D && st_q.pend == 8'h3E) g.ev[i].value = 63'd6;
					else if (!eoi && ch == 8'h3D && st_q.pend == 8'h3C) g.ev[i].value = 63'd7;
					else if (!eoi && ch == 8'h3D && notsign) g.ev[i].value = 63'd8;
					else g.ev[i].kind = slt_pkg::EV_SYMBOL;
					if (nx.tok_cnt == 2'd0) nx.first_id = 1'b0;
					if (nx.tok_cnt != 2'd3) nx.tok_cnt = nx.tok_cnt + 2'd1;
					if (g.ev[i].kind == slt_pkg::EV_DIGRAPH) begin
						nx.mode = slt_pkg::M_IDLE;
					end else begin
						if (st_q.pend == 8'h3F || st_q.pend == 8'h21) nx.expr = 1'b1;
						if (st_q.pend == 8'h3D && !cfg.legacy) nx.eqn = 1'b1;
						g.ev[i].value = notsign ? 63'h5C : {55'd0, st_q.pend};
						go_idle = 1'b1;
					end
					i = i + 2'd1;
				end
			end
			slt_pkg::M_LCOM: begin
				if (eoi || ch == 8'h0A) begin
					g.ev[i].kind = eoi ? slt_pkg::EV_EOF : slt_pkg::EV_EOL;
					g.ev[i].expr = st_q.expr; g.ev[i].eqn = st_q.eqn; i = i + 2'd1;
					nx.expr = 1'b0; nx.eqn = 1'b0; nx.tok_cnt = 2'd0;
					nx.first_id = 1'b0; nx.lines = '0;
					nx.mode = slt_pkg::M_IDLE;
				end
			end
			slt_pkg::M_SKIP: begin
				if (eoi) begin
					g.ev[i].kind = slt_pkg::EV_EOF;
					g.ev[i].expr = st_q.expr; g.ev[i].eqn = st_q.eqn; i = i + 2'd1;
					nx.expr = 1'b0; nx.eqn = 1'b0; nx.tok_cnt = 2'd0;
					nx.first_id = 1'b0; nx.lines = '0;
					nx.mode = slt_pkg::M_IDLE;
				end else if (ch == 8'h0A) begin
					nx.mode = slt_pkg::M_IDLE;
				end
			end
			slt_pkg::M_CSTART, slt_pkg::M_CSKIP, slt_pkg::M_CTEXT, slt_pkg::M_CNL: begin
				if (st_q.mode == slt_pkg::M_CSTART && !eoi && ch == 8'h0A) begin
					if (lc != CNT_MAX) nx.lines = lc + 1'b1;
				end else if (st_q.mode == slt_pkg::M_CSKIP ||
						(st_q.mode == slt_pkg::M_CSTART && cfg.skip)) begin
					nx.mode = slt_pkg::M_CSKIP;
					if (eoi || ch == 8'h3B) begin
						g.ev[i].kind = slt_pkg::EV_CEND;
						g.ev[i].value = {{(slt_pkg::VAL_W-slt_pkg::COMMENT_COUNT_BITS){1'b0}}, lc};
						i = i + 2'd1;
						if (nx.tok_cnt == 2'd0) nx.first_id = 1'b0;
						if (nx.tok_cnt != 2'd3) nx.tok_cnt = nx.tok_cnt + 2'd1;
						nx.mode = slt_pkg::M_IDLE;
						if (eoi) begin
							g.ev[i].kind = slt_pkg::EV_EOF;
							g.ev[i].expr = st_q.expr; g.ev[i].eqn = st_q.eqn; i = i + 2'd1;
							nx.expr = 1'b0; nx.eqn = 1'b0; nx.tok_cnt = 2'd0;
							nx.first_id = 1'b0; nx.lines = '0;
						end
					end else if (ch == 8'h0A) begin
						if (lc != CNT_MAX) nx.lines = lc + 1'b1;
					end
				end else if (st_q.mode == slt_pkg::M_CSTART && !eoi && ch == 8'h3B) begin
					g.ev[i].kind = slt_pkg::EV_CEND;
					g.ev[i].value = {{(slt_pkg::VAL_W-slt_pkg::COMMENT_COUNT_BITS){1'b0}}, lc};
					i = i + 2'd1;
					if (nx.tok_cnt == 2'd0) nx.first_id = 1'b0;
					if (nx.tok_cnt != 2'd3) nx.tok_cnt = nx.tok_cnt + 2'd1;
					nx.mode = slt_pkg::M_IDLE;
				end else begin
					nx.mode = slt_pkg::M_CTEXT;
					if (eoi) begin
						g.ev[i].kind = slt_pkg::EV_CEND;
						g.ev[i].value = {{(slt_pkg::VAL_W-slt_pkg::COMMENT_COUNT_BITS){1'b0}},
							(lc != '0) ? lc - 1'b1 : lc};
						i = i + 2'd1;
						g.ev[i].kind = slt_pkg::EV_EOF;
						g.ev[i].expr = st_q.expr; g.ev[i].eqn = st_q.eqn; i = i + 2'd1;
						nx.expr = 1'b0; nx.eqn = 1'b0; nx.tok_cnt = 2'd0;
						nx.first_id = 1'b0; nx.lines = '0;
						nx.mode = slt_pkg::M_IDLE;
					end else if (ch == 8'h3B) begin
						g.ev[i].kind = slt_pkg::EV_CLINE;
						g.ev[i].value = {{(slt_pkg::VAL_W-slt_pkg::COMMENT_COUNT_BITS){1'b0}}, lc};
						i = i + 2'd1;
						g.ev[i].kind = slt_pkg::EV_CEND;
						g.ev[i].value = {{(slt_pkg::VAL_W-slt_pkg::COMMENT_COUNT_BITS){1'b0}}, lc};
						i = i + 2'd1;
						if (nx.tok_cnt == 2'd0) nx.first_id = 1'b0;
						if (nx.tok_cnt != 2'd3) nx.tok_cnt = nx.tok_cnt + 2'd1;
						nx.mode = slt_pkg::M_IDLE;
					end else if (ch == 8'h0A) begin
						if (st_q.mode == slt_pkg::M_CTEXT) begin
							g.ev[i].kind = slt_pkg::EV_CLINE;
							g.ev[i].value = {{(slt_pkg::VAL_W-slt_pkg::COMMENT_COUNT_BITS){1'b0}}, lc};
							i = i + 2'd1;
						end
						if (lc != CNT_MAX) nx.lines = lc + 1'b1;
						nx.mode = slt_pkg::M_CNL;
					end else begin
						g.ev[i].kind = slt_pkg::EV_CCHAR;
						g.ev[i].value = {55'd0, ch}; i = i + 2'd1;
					end
				end
			end
			default: go_idle = 1'b1;
		endcase

		if (go_str) begin
			nx.mode = slt_pkg::M_STR;
			if (eoi || ch == 8'h0A) begin
				g.ev[i].kind = slt_pkg::EV_BADSTR; i = i + 2'd1;
				nx.expr = 1'b0; nx.eqn = 1'b0; nx.tok_cnt = 2'd0;
				nx.first_id = 1'b0; nx.lines = '0;
				nx.mode = slt_pkg::M_IDLE;
				if (eoi) begin
					g.ev[i].kind = slt_pkg::EV_EOF; i = i + 2'd1;
				end
			end else if (ch == 8'h22) begin
				g.ev[i].kind = slt_pkg::EV_STREND; i = i + 2'd1;
				if (nx.tok_cnt == 2'd0) nx.first_id = 1'b0;
				if (nx.tok_cnt != 2'd3) nx.tok_cnt = nx.tok_cnt + 2'd1;
				nx.mode = slt_pkg::M_IDLE;
			end else if (ch == 8'h5C) begin
				nx.mode = slt_pkg::M_ESC;
			end else begin
				g.ev[i].kind = slt_pkg::EV_STRCHAR; g.ev[i].value = {55'd0, ch}; i = i + 2'd1;
			end
		end

		if (go_idle) begin
			nx.mode = slt_pkg::M_IDLE;
			if (eoi || ch == 8'h0A) begin
				g.ev[i].kind = eoi ? slt_pkg::EV_EOF : slt_pkg::EV_EOL;
				g.ev[i].expr = nx.expr; g.ev[i].eqn = nx.eqn; i = i + 2'd1;
				nx.expr = 1'b0; nx.eqn = 1'b0; nx.tok_cnt = 2'd0;
				nx.first_id = 1'b0; nx.lines = '0;
			end else if (ch == 8'h20 || ch == 8'h09) begin
				nx.mode = slt_pkg::M_IDLE;
			end else if (is_letter(ch)) begin
				g.ev[i].kind = slt_pkg::EV_IDCHAR; g.ev[i].value = {55'd0, ch}; i = i + 2'd1;
				nx.mode = slt_pkg::M_IDENT;
			end else if (is_digit(ch)) begin
				nx.acc = {60'd0, dig};
				nx.mode = slt_pkg::M_NUM;
			end else if (ch == 8'h22) begin
				nx.mode = slt_pkg::M_STR;
			end else begin
				nx.pend = ch;
				nx.mode = slt_pkg::M_PEND;
			end
		end
		g.n = i;
	end

endmodule

// ===== hdl/slt_out_queue.sv =====
// slt_out_queue: holds the up to three events of one character and hands them
// out one per cycle while stall is low. Depends on slt_pkg.
module slt_out_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  slt_pkg::ev_group_t      grp,
	output logic                    can_load,
	output logic                    valid,
	input  logic                    stall,
	output slt_pkg::event_t         ev,
	output logic                    last
);

	slt_pkg::ev_group_t grp_q;
	logic [1:0]         idx_q;
	logic               pop;
	logic               fin;

	assign valid = grp_q.n != 2'd0;
	assign pop = valid && !stall;
	assign fin = idx_q + 2'd1 == grp_q.n;
	assign ev = grp_q.ev[idx_q];
	assign last = fin;
	assign can_load = !valid || (pop && fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
			idx_q <= 2'd0;
		end else if (load) begin
			grp_q <= grp;
			idx_q <= 2'd0;
		end else if (pop) begin
			if (fin) begin
				grp_q.n <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== hdl/source_line_tokenizer.sv =====
// Latency: results of a request appear the cycle after it is accepted.
// Throughput: one request per cycle when it yields at most one event and out_stall
// is low; a request with more events holds in_stall until its last event is taken.
// Reset: arst_n asynchronously returns the lexer to idle with all line state,
// counters and configuration cleared, and the output empty.
module source_line_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  event_kind,
	output logic [62:0] event_value,
	output logic        expression_seen,
	output logic        equation_seen,
	output logic        last,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [0:0]  cfg_data
);

	slt_pkg::cfg_t      cfg_q;
	slt_pkg::ev_group_t grp;
	slt_pkg::event_t    ev;
	logic               can_load;
	logic               step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			if ({1'b0, cfg_index} == slt_pkg::CFG_LEGACY) cfg_q.legacy <= cfg_data[0];
			if ({1'b0, cfg_index} == slt_pkg::CFG_SKIP) cfg_q.skip <= cfg_data[0];
		end
	end

	assign in_stall = !can_load;
	assign step = in_valid && can_load;

	slt_lexer u_lexer (
		.clk(clk), .arst_n(arst_n), .step(step), .ch(char_code),
		.eoi(end_of_input), .cfg(cfg_q), .evs(grp)
	);

	slt_out_queue u_queue (
		.clk(clk), .arst_n(arst_n), .load(step), .grp(grp),
		.can_load(can_load), .valid(out_valid), .stall(out_stall),
		.ev(ev), .last(last)
	);

	assign event_kind = ev.kind;
	assign event_value = ev.value;
	assign expression_seen = ev.expr;
	assign equation_seen = ev.eqn;

endmodule

// ===== hdl/slt_checker.sv =====
// slt_checker: port-level checks for source_line_tokenizer, bound to it.
// Depends on slt_pkg.
module slt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  event_kind,
	input logic [62:0] event_value,
	input logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(event_value))
		else $error("stalled result changed");

	a_eol_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == slt_pkg::EV_EOL || event_kind == slt_pkg::EV_EOF)
		|-> last)
		else $error("line end not last");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("accepted while results pending");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == slt_pkg::EV_IDEND |-> event_value == 63'd0)
		else $error("identend carries value");

endmodule

bind source_line_tokenizer slt_checker u_slt_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .event_kind(event_kind),
	.event_value(event_value), .last(last)
);
